// ----- src/pli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Positional list package
// Shared sizes, operation and status codes, and the cell control type.
// -----------------------------------------------------------------------------
package pli_pkg;

  localparam int CAPACITY = 32;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos_idx;
    logic [WORD_W-1:0] new_word;
  } cell_op_t;

endpackage
`default_nettype wire

// ----- src/pli_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry and takes its neighbor's word when the list shifts.
// -----------------------------------------------------------------------------
module pli_cell (
  input  wire                          clk_i,
  input  wire [pli_pkg::IDX_W-1:0]     idx_i,
  input  wire pli_pkg::cell_op_t       op_i,
  input  wire [pli_pkg::WORD_W-1:0]    left_i,
  input  wire [pli_pkg::WORD_W-1:0]    right_i,
  output logic [pli_pkg::WORD_W-1:0]   word_o
);

  logic [pli_pkg::WORD_W-1:0] word_q, word_d;
  logic at_pos, above_pos;

  assign at_pos    = (idx_i == op_i.pos_idx);
  assign above_pos = (idx_i > op_i.pos_idx);

  always_comb begin
    word_d = word_q;
    if (op_i.ins) begin
      if (at_pos) begin
        word_d = op_i.new_word;
      end else if (above_pos) begin
        word_d = left_i;
      end
    end else if (op_i.del && (at_pos || above_pos)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

// ----- src/positional_list_insert_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Positional list with insert and delete
// Ordered list of 64-bit words with 1-based positions, kept in a row of cells.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tuser: mode; tdata: position, in_word
// m_axis    out  m_axis_tvalid/m_axis_tready tuser: status; tdata: out_word, length
//
// All cells shift at once, and a get reads one cell through a single
// selector. The result sits in an output register, and a new transfer
// is taken whenever that register is empty or being read.
// Reset clears the length and the output valid; the entries are not cleared.
// A stalled output holds the next operation back by blocking s_axis_tready.
// -----------------------------------------------------------------------------
module positional_list_insert_delete (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [1:0]  s_axis_tuser,   // [1:0] mode
  input  wire  [71:0] s_axis_tdata,   // [5:0] position, [69:6] in_word, zero pad
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic [71:0] m_axis_tdata    // [63:0] out_word, [69:64] length, zero pad
);

  localparam int CAP = pli_pkg::CAPACITY;
  localparam int WW  = pli_pkg::WORD_W;

  logic [1:0]                 mode;
  logic [pli_pkg::POS_W-1:0]  position;
  logic [WW-1:0]              in_word;
  logic                       accept;

  logic [pli_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       out_valid_q;
  logic [1:0]                 out_status_q, status;
  logic [WW-1:0]              out_word_q, res_word;
  logic [pli_pkg::CNT_W-1:0]  out_len_q;

  logic [pli_pkg::CMP_W-1:0]  pos_ext, cnt_ext;
  logic                       empty, full, rd_range, ins_range;
  logic [pli_pkg::IDX_W-1:0]  pos_idx;
  pli_pkg::cell_op_t          op;
  logic [WW-1:0]              cell_word [CAP];

  assign mode     = s_axis_tuser;
  assign position = s_axis_tdata[pli_pkg::POS_W-1:0];
  assign in_word  = s_axis_tdata[pli_pkg::POS_W +: WW];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_ext   = pli_pkg::CMP_W'(position);
  assign cnt_ext   = pli_pkg::CMP_W'(count_q);
  assign empty     = (count_q == '0);
  assign full      = (count_q == pli_pkg::CNT_W'(CAP));
  assign rd_range  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign ins_range = (pos_ext == '0) || (pos_ext > (cnt_ext + pli_pkg::CMP_W'(1)));
  assign pos_idx   = pli_pkg::IDX_W'(position - pli_pkg::POS_W'(1));

  always_comb begin
    unique case (mode)
      pli_pkg::MODE_GET, pli_pkg::MODE_DELETE: begin
        if (empty) begin
          status = pli_pkg::ST_EMPTY;
        end else if (rd_range) begin
          status = pli_pkg::ST_RANGE;
        end else begin
          status = pli_pkg::ST_OK;
        end
      end
      pli_pkg::MODE_INSERT: begin
        if (full) begin
          status = pli_pkg::ST_FULL;
        end else if (ins_range) begin
          status = pli_pkg::ST_RANGE;
        end else begin
          status = pli_pkg::ST_OK;
        end
      end
      default: begin
        status = pli_pkg::ST_RANGE;
      end
    endcase
  end

  assign op.ins      = accept && (mode == pli_pkg::MODE_INSERT) && (status == pli_pkg::ST_OK);
  assign op.del      = accept && (mode == pli_pkg::MODE_DELETE) && (status == pli_pkg::ST_OK);
  assign op.pos_idx  = pos_idx;
  assign op.new_word = in_word;

  for (genvar k = 0; k < CAP; k++) begin : g_cell
    logic [WW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[k-1];
    end
    if (k == CAP - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[k+1];
    end
    pli_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (pli_pkg::IDX_W'(k)),
      .op_i    (op),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[k])
    );
  end

  always_comb begin
    res_word = '0;
    if ((status == pli_pkg::ST_OK) &&
        ((mode == pli_pkg::MODE_GET) || (mode == pli_pkg::MODE_DELETE))) begin
      res_word = cell_word[pos_idx];
    end
  end

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + pli_pkg::CNT_W'(1);
    end else if (op.del) begin
      count_d = count_q - pli_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status;
      out_word_q   <= res_word;
      out_len_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(72 - WW - pli_pkg::POS_W)'(0),
                          pli_pkg::POS_W'(out_len_q), out_word_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pli_pkg::CNT_W'(CAP))
    else $error("list length above capacity");

  a_len_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_len_q == count_q))
    else $error("reported length differs from list length");

  a_err_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status != pli_pkg::ST_OK)) |=> (count_q == $past(count_q)))
    else $error("failed operation changed the length");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != pli_pkg::ST_OK)) |-> (out_word_q == '0))
    else $error("error result carries a nonzero word");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.ins |=> (count_q == $past(count_q) + pli_pkg::CNT_W'(1)))
    else $error("insert did not grow the list");

endmodule
`default_nettype wire

// ----- tb/sv/tb_positional_list_insert_delete.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Positional list testbench
// Drives get, insert and delete operations into the list and checks every
// result against a list model that runs alongside. The model is updated as
// each input transfer is accepted. Both sides of the stream idle at random.
// -----------------------------------------------------------------------------
module tb_positional_list_insert_delete;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int N_RANDOM = 850;

  typedef struct packed {
    logic        hold;
    logic [1:0]  mode;
    logic [5:0]  pos;
    logic [63:0] word;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word;
    logic [5:0]  len;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic [71:0] s_axis_tdata = '0;   // [5:0] position, [69:6] in_word, zero pad
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [1:0]  m_axis_tuser;        // [1:0] status
  wire  [71:0] m_axis_tdata;        // [63:0] out_word, [69:64] length, zero pad

  list_cmd_t    cmd_q[$];
  list_result_t expected_q[$];

  logic [63:0]  list_words [pli_pkg::CAPACITY];
  int unsigned  list_len;
  int unsigned  gen_len;

  int unsigned  error_count;
  int unsigned  n_results;
  int unsigned  n_ok, n_empty, n_full, n_range;
  int unsigned  max_len;

  int unsigned  send_idle, send_calm;
  int unsigned  sink_idle, sink_calm;
  list_cmd_t    next_cmd;
  list_result_t want;

  positional_list_insert_delete uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic list_result_t apply_list_op(input logic [1:0] mode,
                                                 input logic [5:0] pos,
                                                 input logic [63:0] word);
    list_result_t res;
    int k;
    res.status = pli_pkg::ST_OK;
    res.word   = '0;
    case (mode)
      pli_pkg::MODE_GET: begin
        if (list_len == 0) begin
          res.status = pli_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          res.status = pli_pkg::ST_RANGE;
        end else begin
          res.word = list_words[pos - 1];
        end
      end
      pli_pkg::MODE_INSERT: begin
        if (list_len >= pli_pkg::CAPACITY) begin
          res.status = pli_pkg::ST_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          res.status = pli_pkg::ST_RANGE;
        end else begin
          for (k = list_len; k >= pos; k--) list_words[k] = list_words[k - 1];
          list_words[pos - 1] = word;
          list_len++;
        end
      end
      pli_pkg::MODE_DELETE: begin
        if (list_len == 0) begin
          res.status = pli_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          res.status = pli_pkg::ST_RANGE;
        end else begin
          res.word = list_words[pos - 1];
          for (k = pos; k < list_len; k++) list_words[k - 1] = list_words[k];
          list_len--;
        end
      end
      default: res.status = pli_pkg::ST_RANGE;
    endcase
    res.len = 6'(list_len);
    return res;
  endfunction

  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_cmd(input logic [1:0] mode, input logic [5:0] pos,
                                    input logic [63:0] word);
    list_cmd_t c;
    c.hold = 1'b0;
    c.mode = mode;
    c.pos  = pos;
    c.word = word;
    cmd_q.push_back(c);
    if (mode == pli_pkg::MODE_INSERT && gen_len < pli_pkg::CAPACITY &&
        pos >= 1 && pos <= gen_len + 1)
      gen_len++;
    else if (mode == pli_pkg::MODE_DELETE && gen_len > 0 && pos >= 1 && pos <= gen_len)
      gen_len--;
  endfunction

  function automatic void queue_hold();
    list_cmd_t c;
    c = '0;
    c.hold = 1'b1;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [5:0] held_pos();
    if (gen_len == 0) return 6'd1;
    return 6'($urandom_range(1, gen_len));
  endfunction

  function automatic logic [5:0] insert_pos();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 6'd1;
    if (r == 1) return 6'(gen_len + 1);
    return 6'($urandom_range(1, gen_len + 1));
  endfunction

  // Driver: takes the next operation from the queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= '0;
      s_axis_tdata  <= '0;
      send_idle = 0;
      send_calm = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 63) == 0) send_calm = 60;
        send_idle = pick_idle(send_calm > 0);
      end
      if (send_idle > 0) begin
        send_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q[0].hold) begin
        if (!s_axis_tvalid && expected_q.size() == 0) next_cmd = cmd_q.pop_front();
        s_axis_tvalid <= 1'b0;
      end else begin
        next_cmd = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_cmd.mode;
        s_axis_tdata  <= {2'b00, next_cmd.word, next_cmd.pos};
      end
    end
  end

  // Receiver: random stalls on the result stream.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_idle = 0;
      sink_calm = 0;
    end else begin
      if (sink_idle == 0) begin
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 255) == 0) sink_calm = 80;
        sink_idle = pick_idle(sink_calm > 0);
      end
      if (sink_idle > 0) begin
        sink_idle--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transfer, then updates the list model with
  // any input transfer taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      foreach (list_words[i]) list_words[i] = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d word %h",
                                    m_axis_tuser, m_axis_tdata[63:0]));
        end else begin
          want = expected_q.pop_front();
          n_results++;
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      n_results, m_axis_tuser, want.status));
          if (m_axis_tdata[63:0] !== want.word)
            report_mismatch($sformatf("result %0d word %h, expected %h",
                                      n_results, m_axis_tdata[63:0], want.word));
          if (m_axis_tdata[69:64] !== want.len)
            report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                      n_results, m_axis_tdata[69:64], want.len));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_list_op(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[69:6]);
        expected_q.push_back(want);
        case (want.status)
          pli_pkg::ST_OK:    n_ok++;
          pli_pkg::ST_EMPTY: n_empty++;
          pli_pkg::ST_FULL:  n_full++;
          default:           n_range++;
        endcase
        if (want.len > max_len) max_len = want.len;
      end
    end
  end

  initial begin
    int unsigned r;
    bit growing;
    int unsigned full_hits;
    error_count = 0;
    n_results = 0;
    n_ok = 0;
    n_empty = 0;
    n_full = 0;
    n_range = 0;
    max_len = 0;
    gen_len = 0;
    growing = 1'b1;
    full_hits = 0;

    // Empty list, bad positions, unused mode, then a short list worked over.
    queue_cmd(pli_pkg::MODE_GET, 6'd1, rand_word());
    queue_cmd(pli_pkg::MODE_DELETE, 6'd0, rand_word());
    queue_cmd(pli_pkg::MODE_INSERT, 6'd0, rand_word());
    queue_cmd(pli_pkg::MODE_INSERT, 6'd2, rand_word());
    queue_cmd(MODE_UNUSED, 6'd1, rand_word());
    queue_cmd(pli_pkg::MODE_INSERT, 6'd1, '1);
    queue_cmd(pli_pkg::MODE_INSERT, 6'd1, '0);
    queue_cmd(pli_pkg::MODE_INSERT, 6'd3, 64'hA5A5_5A5A_C3C3_3C3C);
    queue_cmd(pli_pkg::MODE_INSERT, 6'd63, rand_word());
    queue_cmd(pli_pkg::MODE_GET, 6'd0, rand_word());
    queue_cmd(pli_pkg::MODE_GET, 6'd4, rand_word());
    queue_cmd(pli_pkg::MODE_GET, 6'd63, '1);
    queue_cmd(pli_pkg::MODE_GET, 6'd1, rand_word());
    queue_cmd(pli_pkg::MODE_GET, 6'd2, rand_word());
    queue_cmd(pli_pkg::MODE_GET, 6'd3, rand_word());
    queue_cmd(pli_pkg::MODE_DELETE, 6'd4, rand_word());
    queue_cmd(pli_pkg::MODE_DELETE, 6'd63, rand_word());
    queue_cmd(pli_pkg::MODE_DELETE, 6'd2, rand_word());
    queue_cmd(MODE_UNUSED, 6'd63, '1);
    queue_cmd(pli_pkg::MODE_DELETE, 6'd2, rand_word());
    queue_cmd(pli_pkg::MODE_DELETE, 6'd1, rand_word());
    queue_hold();

    // Random part: the list is filled up to full and drained to empty again
    // and again, with stray operations mixed in.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 100) queue_hold();
      r = $urandom_range(0, 199);
      if (growing && gen_len == pli_pkg::CAPACITY) begin
        queue_cmd(pli_pkg::MODE_INSERT,
                  (full_hits == 0) ? 6'd0 : 6'($urandom_range(0, 63)), rand_word());
        full_hits++;
        growing = 1'b0;
      end else if (!growing && gen_len == 0) begin
        queue_cmd(pli_pkg::MODE_DELETE, 6'($urandom_range(0, 63)), rand_word());
        growing = 1'b1;
      end else if (r < 20) begin
        queue_cmd(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), rand_word());
      end else if (r < 70) begin
        if (r == 20) growing = !growing;
        queue_cmd(pli_pkg::MODE_GET, held_pos(), rand_word());
      end else if (r < 100) begin
        if (growing) queue_cmd(pli_pkg::MODE_DELETE, held_pos(), rand_word());
        else queue_cmd(pli_pkg::MODE_INSERT, insert_pos(), rand_word());
      end else begin
        if (growing) queue_cmd(pli_pkg::MODE_INSERT, insert_pos(), rand_word());
        else queue_cmd(pli_pkg::MODE_DELETE, held_pos(), rand_word());
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results: %0d ok, %0d empty, %0d full, %0d out of range.",
             n_results, n_ok, n_empty, n_full, n_range);
    $display("The list reached a length of %0d; %0d errors found.", max_len, error_count);
    if (error_count == 0) begin
      $display("positional_list_insert_delete: match");
    end else begin
      $display("positional_list_insert_delete: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", expected_q.size());
    $display("positional_list_insert_delete: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pli_pkg.sv
src/pli_cell.sv
src/positional_list_insert_delete.sv
tb/sv/tb_positional_list_insert_delete.sv
